@@ hw/rtl/bce_pkg.sv @@
`default_nettype none

package bce_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SCALE_W = 13;
  localparam int MV_W = 13;
  localparam int CHARGE_W = 10;
  localparam int SUM_W = 16;
  localparam int CNT_W = 4;
  localparam int IDX_W = 5;
  localparam int DIV_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int FRAC_W = 11;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W = 22;

  localparam int SAMPLES_AVG_DEF = 4;
  localparam int TABLE_POINTS_DEF = 21;
  localparam int TABLE_SLOTS = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd4741;
  localparam logic [FRAC_W-1:0] STEP_TENTHS = 11'd50;
  localparam logic [CHARGE_W-1:0] CHARGE_MAX = 10'd1000;

  typedef struct packed {
    logic acc;
    logic avg_start;
    logic scale;
    logic set_zero;
    logic set_full;
    logic n_init;
    logic n_inc;
    logic frac_start;
    logic set_frac;
    logic load_out;
  } bce_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic le_first;
    logic ge_last;
    logic le_point;
    logic out_free;
  } bce_status_t;

  function automatic logic [MV_W-1:0] bce_volt(input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      5'd0: v = 13'd3300;
      5'd1: v = 13'd3500;
      5'd2: v = 13'd3690;
      5'd3: v = 13'd3710;
      5'd4: v = 13'd3730;
      5'd5: v = 13'd3750;
      5'd6: v = 13'd3770;
      5'd7: v = 13'd3790;
      5'd8: v = 13'd3800;
      5'd9: v = 13'd3820;
      5'd10: v = 13'd3840;
      5'd11: v = 13'd3850;
      5'd12: v = 13'd3870;
      5'd13: v = 13'd3910;
      5'd14: v = 13'd3950;
      5'd15: v = 13'd3980;
      5'd16: v = 13'd4020;
      5'd17: v = 13'd4080;
      5'd18: v = 13'd4110;
      5'd19: v = 13'd4150;
      default: v = 13'd4200;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/battery_charge_estimator_core.sv @@
// result path: the last word of a group starts the average, scale and check states;
// a voltage off the table ends is delivered straight away, else the table search
// and the fraction divider run first; the output waits while it is stalled
// throughput: one sample word per cycle within a group; the input stays stalled
// after the closing word until its result is loaded
// reset: synchronous, active high; clears sum, count, output valid, controller; scale_q12 = 4741
`default_nettype none

module battery_charge_estimator_core import bce_pkg::*; #(
  parameter int SAMPLES_AVG = SAMPLES_AVG_DEF,
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [MV_W-1:0]          voltage_mv,
  output logic [CHARGE_W-1:0]      charge_tenths,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [SCALE_W-1:0]  cfg_data
);

  bce_cmd_t    cmd;
  bce_status_t st;

  assign cfg_ready = 1'b1;

  bce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bce_dp #(
    .SAMPLES_AVG  (SAMPLES_AVG),
    .TABLE_POINTS (TABLE_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .voltage_mv    (voltage_mv),
    .charge_tenths (charge_tenths),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bce_div.sv @@
`default_nettype none

module bce_div import bce_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvsr;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign trial = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a run");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bce_ctrl.sv @@
`default_nettype none

module bce_ctrl import bce_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire bce_status_t st,
  output bce_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_AVG_START = 7'b0000010,
    S_SCALE     = 7'b0000100,
    S_CHECK     = 7'b0001000,
    S_SEARCH    = 7'b0010000,
    S_FRAC_WAIT = 7'b0100000,
    S_DELIVER   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (st.last) state_next = S_AVG_START;
        end
      end
      S_AVG_START: begin
        cmd.avg_start = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.le_first) begin
          cmd.set_zero = 1'b1;
          state_next = S_DELIVER;
        end else if (st.ge_last) begin
          cmd.set_full = 1'b1;
          state_next = S_DELIVER;
        end else begin
          cmd.n_init = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (st.le_point) begin
          cmd.frac_start = 1'b1;
          state_next = S_FRAC_WAIT;
        end else begin
          cmd.n_inc = 1'b1;
        end
      end
      S_FRAC_WAIT: begin
        if (st.div_done) begin
          cmd.set_frac = 1'b1;
          state_next = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_search_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_SEARCH) |-> $past(state == S_CHECK))
    else $error("search entered from wrong state");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bce_dp.sv @@
`default_nettype none

module bce_dp import bce_pkg::*; #(
  parameter int SAMPLES_AVG = SAMPLES_AVG_DEF,
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                cfg_we,
  input  wire logic [SCALE_W-1:0]  cfg_data,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [MV_W-1:0]          voltage_mv,
  output logic [CHARGE_W-1:0]      charge_tenths,
  input  wire bce_cmd_t            cmd,
  output bce_status_t              st
);

  localparam int P_USED = (TABLE_POINTS < 2) ? 2 :
                          ((TABLE_POINTS > TABLE_SLOTS) ? TABLE_SLOTS : TABLE_POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(P_USED - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_AVG - 1);
  // ceil(2^21 / group) gives an exact floor quotient for any 16-bit sum
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + SAMPLES_AVG - 1) / SAMPLES_AVG);

  logic [SCALE_W-1:0]  scale_q12;
  logic [SUM_W-1:0]    sample_sum;
  logic [CNT_W-1:0]    sample_count;
  logic [SAMPLE_W-1:0] avg;
  logic [MV_W-1:0]     mv;
  logic [IDX_W-1:0]    n;
  logic [CHARGE_W-1:0] charge;

  logic [MV_W-1:0]             pt_lo;
  logic [MV_W-1:0]             pt_hi;
  logic [SUM_W+RECIP_W-1:0]    avg_prod;
  logic                        div_start;
  logic [DIV_W-1:0]            div_dividend;
  logic [DIV_W-1:0]            div_divisor;
  logic                        div_done;
  logic [DIV_W-1:0]            quotient;
  logic [SAMPLE_W+SCALE_W-1:0] product;
  logic [FRAC_W-1:0]           frac_sum;

  assign pt_lo = bce_volt(n - 1'b1);
  assign pt_hi = bce_volt(n);

  assign avg_prod = {{RECIP_W{1'b0}}, sample_sum} * {{SUM_W{1'b0}}, RECIP};

  assign div_start = cmd.frac_start;
  assign div_dividend = DIV_W'(DIV_W'(mv - pt_lo) * DIV_W'(STEP_TENTHS));
  assign div_divisor = DIV_W'(pt_hi - pt_lo);

  bce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign product = {{SCALE_W{1'b0}}, avg} *
                   {{SAMPLE_W{1'b0}}, scale_q12};
  assign frac_sum = FRAC_W'(n - 1'b1) * STEP_TENTHS + FRAC_W'(quotient[5:0]);

  assign st.last = (sample_count == LAST_CNT);
  assign st.div_done = div_done;
  assign st.le_first = (mv <= bce_volt('0));
  assign st.ge_last = (mv >= bce_volt(LAST_IDX));
  assign st.le_point = (mv <= pt_hi);
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q12 <= SCALE_RESET;
      sample_sum <= '0;
      sample_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) scale_q12 <= cfg_data;
      if (cmd.avg_start) begin
        sample_sum <= '0;
        sample_count <= '0;
      end else if (cmd.acc) begin
        sample_sum <= sample_sum + SUM_W'(sample);
        if (!st.last) sample_count <= sample_count + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_start) avg <= avg_prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
    if (cmd.scale) mv <= product[SAMPLE_W+SCALE_W-1:SAMPLE_W];
    if (cmd.n_init) begin
      n <= IDX_W'(1);
    end else if (cmd.n_inc) begin
      n <= n + 1'b1;
    end
    if (cmd.set_zero) begin
      charge <= '0;
    end else if (cmd.set_full) begin
      charge <= CHARGE_MAX;
    end else if (cmd.set_frac) begin
      charge <= (frac_sum > FRAC_W'(CHARGE_MAX)) ? CHARGE_MAX : frac_sum[CHARGE_W-1:0];
    end
    if (cmd.load_out) begin
      voltage_mv <= mv;
      charge_tenths <= charge;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LAST_CNT)
    else $error("sample count past group size");
  a_charge_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> charge_tenths <= CHARGE_MAX)
    else $error("charge above full scale");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none

module testbench;
  import bce_pkg::*;

  localparam int GROUP = SAMPLES_AVG_DEF;
  localparam int POINTS = TABLE_POINTS_DEF;
  localparam int MV_MAX = (1 << MV_W) - 1;
  localparam int BLOCK_LATENCY = 64;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic [CHARGE_W-1:0] charge;
  } reading_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_stall;
  logic [MV_W-1:0] voltage_mv;
  logic [CHARGE_W-1:0] charge_tenths;
  logic cfg_valid;
  logic cfg_ready;
  logic [SCALE_W-1:0] cfg_data;

  int knee_mv [0:TABLE_SLOTS-1] = '{
    3300, 3500, 3690, 3710, 3730, 3750, 3770, 3790, 3800, 3820,
    3840, 3850, 3870, 3910, 3950, 3980, 4020, 4080, 4110, 4150,
    4200, 4200, 4200, 4200, 4200, 4200, 4200, 4200, 4200, 4200,
    4200, 4200
  };

  reading_t pending_readings[$];
  int group_sum;
  int group_count;
  int scale_now;
  int errors;
  int idle_cycles;
  int stall_hold;
  int stall_pick;
  logic quiet;

  battery_charge_estimator_core #(
    .SAMPLES_AVG(GROUP),
    .TABLE_POINTS(POINTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .voltage_mv(voltage_mv),
    .charge_tenths(charge_tenths),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CHARGE_W-1:0] charge_from_mv(input int mv);
    int pts;
    int n;
    int c;
    pts = POINTS;
    if (pts < 2) pts = 2;
    if (pts > TABLE_SLOTS) pts = TABLE_SLOTS;
    if (mv <= knee_mv[0]) return '0;
    if (mv >= knee_mv[pts-1]) return CHARGE_MAX;
    for (n = 1; n < pts; n++) begin
      if (mv <= knee_mv[n]) begin
        c = 50 * (n - 1);
        if (knee_mv[n] != knee_mv[n-1]) begin
          c += (50 * (mv - knee_mv[n-1])) / (knee_mv[n] - knee_mv[n-1]);
        end
        if (c > CHARGE_MAX) c = CHARGE_MAX;
        return c[CHARGE_W-1:0];
      end
    end
    return CHARGE_MAX;
  endfunction

  task automatic take_sample(input logic [SAMPLE_W-1:0] w);
    reading_t r;
    int avg;
    int mv;
    group_sum = (group_sum + w) & 16'hFFFF;
    if (group_count + 1 < GROUP) begin
      group_count++;
      return;
    end
    avg = group_sum / GROUP;
    mv = (avg * scale_now) >>> 12;
    if (mv > MV_MAX) mv = MV_MAX;
    r.mv = mv[MV_W-1:0];
    r.charge = charge_from_mv(mv);
    pending_readings.push_back(r);
    group_sum = 0;
    group_count = 0;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // valid stays high after the word is taken; settle lowers it, and the next call lowers it only when it draws a gap
  task automatic send_word(input logic [SAMPLE_W-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_sample(w);
  endtask

  task automatic send_flat(input int w, input int extra);
    int i;
    for (i = 0; i < GROUP - 1; i++) send_word(w[SAMPLE_W-1:0]);
    send_word(SAMPLE_W'(w + extra));
  endtask

  function automatic logic [SAMPLE_W-1:0] sample_near(input int mv_target);
    int code;
    code = (scale_now == 0) ? 4095 : (mv_target * 4096) / scale_now;
    code = code + $urandom_range(0, 8) - 4;
    if (code < 0) code = 0;
    if (code > 4095) code = 4095;
    return code[SAMPLE_W-1:0];
  endfunction

  task automatic send_random_group();
    int i;
    int target;
    target = $urandom_range(3200, 4300);
    for (i = 0; i < GROUP; i++) begin
      if ($urandom_range(0, 99) < 80) send_word(sample_near(target));
      else send_word($urandom_range(0, 4095));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  task automatic set_scale(input int value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value[SCALE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    scale_now = value & 16'h1FFF;
  endtask

  task automatic test_table_points();
    quiet <= 1'b0;
    send_flat(0, 0);
    send_flat(4095, 0);
    set_scale(4096);
    // unity scale, truncated average lands on table points
    send_flat(3300, 3);
    send_flat(3500, 0);
    // full scale reaches the top segment and the last point
    set_scale(8191);
    send_flat(2100, 0);
    send_flat(2101, 0);
  endtask

  task automatic test_scale_extremes();
    int i;
    set_scale(0);
    for (i = 0; i < 6; i++) send_random_group();
    send_flat(4095, 0);
    set_scale(8191);
    for (i = 0; i < 6; i++) send_random_group();
    send_flat(4095, 0);
    send_flat(0, 0);
    set_scale(SCALE_RESET);
    for (i = 0; i < 6; i++) send_random_group();
  endtask

  task automatic test_random_groups();
    int g;
    for (g = 0; g < 480; g++) begin
      if (g % 60 == 59) begin
        if ($urandom_range(0, 3) == 0) set_scale($urandom_range(0, 8191));
        else set_scale($urandom_range(4300, 6000));
      end
      quiet <= (g % 50) < 8;
      if ($urandom_range(0, 99) < 85) send_random_group();
      else send_flat($urandom_range(0, 4095), 0);
    end
    quiet <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 6);
      end else if (stall_pick < 93) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(15, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected result voltage_mv %0d charge_tenths %0d",
                 $time, voltage_mv, charge_tenths);
        errors++;
      end else begin
        if (voltage_mv !== pending_readings[0].mv) begin
          $display("%0t voltage_mv expected %0d got %0d",
                   $time, pending_readings[0].mv, voltage_mv);
          errors++;
        end
        if (charge_tenths !== pending_readings[0].charge) begin
          $display("%0t charge_tenths expected %0d got %0d",
                   $time, pending_readings[0].charge, charge_tenths);
          errors++;
        end
        void'(pending_readings.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    group_sum = 0;
    group_count = 0;
    scale_now = SCALE_RESET;
    errors = 0;
    idle_cycles = 0;
    stall_hold = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_points();
    test_scale_extremes();
    test_random_groups();

    settle();
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
